FILE: rtl/core/psl_pkg.sv
// package: shared types, constants and codes of the passive serial loader
`default_nettype none
package psl_pkg;

   localparam int INDEX_WIDTH   = 24;
   localparam int IMAGE_WIDTH   = 24;
   localparam int EXTRA_WIDTH   = 16;
   localparam int BYTE_WIDTH    = 8;
   localparam int BITS_PER_BYTE = 8;
   localparam int BIT_CNT_WIDTH = $clog2(BITS_PER_BYTE);
   localparam int STATUS_WIDTH  = 2;
   localparam int CSR_IDX_WIDTH = 1;
   localparam int CSR_DAT_WIDTH = 24;

   localparam logic [IMAGE_WIDTH-1:0] IMAGE_RESET = '1;
   localparam logic [EXTRA_WIDTH-1:0] EXTRA_RESET = EXTRA_WIDTH'(4000);

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_IMAGE_BYTES  = 1'd0,
      CSR_EXTRA_CLOCKS = 1'd1
   } csr_index_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_IDLE = 2'd0,
      STATUS_BUSY = 2'd1,
      STATUS_DONE = 2'd2,
      STATUS_FAIL = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_HOLD   = 3'd1,
      MODE_WAITST = 3'd2,
      MODE_FETCH  = 3'd3,
      MODE_SHIFT  = 3'd4,
      MODE_EXTRA  = 3'd5,
      MODE_DONE   = 3'd6,
      MODE_FAIL   = 3'd7
   } mode_type;

   typedef struct packed {
      logic                  start_req;
      logic                  nstatus_pin;
      logic                  cdone_pin;
      logic                  byte_valid;
      logic [BYTE_WIDTH-1:0] image_byte;
   } tick_type;

   typedef struct packed {
      logic                   nconfig_out;
      logic                   dclk_out;
      logic                   data0_out;
      logic                   need_byte;
      logic [INDEX_WIDTH-1:0] byte_index;
      status_type             run_status;
   } result_type;

endpackage
`default_nettype wire

FILE: rtl/core/psl_csr.sv
// configuration registers: image length and trailing clock count
`default_nettype none
module psl_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [psl_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  wire logic [psl_pkg::CSR_DAT_WIDTH-1:0]   csr_wdata,
   output      logic [psl_pkg::IMAGE_WIDTH-1:0]     image_bytes,
   output      logic [psl_pkg::EXTRA_WIDTH-1:0]     extra_clocks
);

   logic [psl_pkg::IMAGE_WIDTH-1:0] image_ff, image_in;
   logic [psl_pkg::EXTRA_WIDTH-1:0] extra_ff, extra_in;

   assign csr_ready = 1'b1;

   always_comb begin
      image_in = image_ff;
      extra_in = extra_ff;
      if (csr_valid) begin
         case (psl_pkg::csr_index_type'(csr_index))
            psl_pkg::CSR_IMAGE_BYTES:  image_in = csr_wdata[psl_pkg::IMAGE_WIDTH-1:0];
            psl_pkg::CSR_EXTRA_CLOCKS: extra_in = csr_wdata[psl_pkg::EXTRA_WIDTH-1:0];
            default:                   image_in = image_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_ff <= psl_pkg::IMAGE_RESET;
         extra_ff <= psl_pkg::EXTRA_RESET;
      end else begin
         image_ff <= image_in;
         extra_ff <= extra_in;
      end
   end

   assign image_bytes  = image_ff;
   assign extra_clocks = extra_ff;

endmodule
`default_nettype wire

FILE: rtl/core/psl_engine.sv
// sequencer: pin levels per tick, byte shifter, byte counter, trailing clocks
`default_nettype none
module psl_engine (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            step_en,
   input  wire psl_pkg::tick_type               tick,
   input  wire logic [psl_pkg::IMAGE_WIDTH-1:0] image_bytes,
   input  wire logic [psl_pkg::EXTRA_WIDTH-1:0] extra_clocks,
   output      psl_pkg::result_type             result
);

   psl_pkg::mode_type                 mode_ff, mode_in;
   logic [psl_pkg::BYTE_WIDTH-1:0]    shift_ff, shift_in;
   logic [psl_pkg::BIT_CNT_WIDTH-1:0] bit_cnt_ff, bit_cnt_in;
   logic                              phase_ff, phase_in;
   logic [psl_pkg::INDEX_WIDTH-1:0]   sent_ff, sent_in;
   logic [psl_pkg::EXTRA_WIDTH-1:0]   extra_ff, extra_in;
   logic                              below_end;

   assign below_end = sent_ff < image_bytes;

   // next state
   always_comb begin
      mode_in    = mode_ff;
      shift_in   = shift_ff;
      bit_cnt_in = bit_cnt_ff;
      phase_in   = phase_ff;
      sent_in    = sent_ff;
      extra_in   = extra_ff;
      case (mode_ff)
         psl_pkg::MODE_HOLD: begin
            if (!tick.nstatus_pin || !tick.cdone_pin) mode_in = psl_pkg::MODE_WAITST;
         end
         psl_pkg::MODE_WAITST: begin
            if (tick.nstatus_pin) mode_in = psl_pkg::MODE_FETCH;
         end
         psl_pkg::MODE_FETCH: begin
            if (tick.byte_valid) begin
               shift_in   = tick.image_byte;
               bit_cnt_in = '0;
               phase_in   = 1'b0;
               // saturate at image end and at counter width
               if (below_end && (sent_ff != '1)) sent_in = sent_ff + 1'b1;
               mode_in = psl_pkg::MODE_SHIFT;
            end
         end
         psl_pkg::MODE_SHIFT: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               shift_in = {1'b0, shift_ff[psl_pkg::BYTE_WIDTH-1:1]};
               if (bit_cnt_ff == psl_pkg::BIT_CNT_WIDTH'(psl_pkg::BITS_PER_BYTE - 1)) begin
                  bit_cnt_in = '0;
                  if (tick.cdone_pin || !below_end) begin
                     if (below_end) begin
                        extra_in = extra_clocks;
                        mode_in  = (extra_clocks == '0) ? psl_pkg::MODE_DONE
                                                        : psl_pkg::MODE_EXTRA;
                     end else begin
                        mode_in = psl_pkg::MODE_FAIL;
                     end
                  end else begin
                     mode_in = psl_pkg::MODE_FETCH;
                  end
               end else begin
                  bit_cnt_in = bit_cnt_ff + 1'b1;
               end
            end
         end
         psl_pkg::MODE_EXTRA: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               extra_in = extra_ff - 1'b1;
               if (extra_ff == psl_pkg::EXTRA_WIDTH'(1)) mode_in = psl_pkg::MODE_DONE;
            end
         end
         psl_pkg::MODE_IDLE, psl_pkg::MODE_DONE, psl_pkg::MODE_FAIL: begin
            if (tick.start_req) begin
               sent_in    = '0;
               bit_cnt_in = '0;
               phase_in   = 1'b0;
               shift_in   = '0;
               extra_in   = '0;
               mode_in    = psl_pkg::MODE_HOLD;
            end
         end
         default: mode_in = psl_pkg::MODE_IDLE;
      endcase
   end

   // outputs from the state held before the tick, index after it
   always_comb begin
      result.nconfig_out = (mode_ff != psl_pkg::MODE_HOLD);
      result.dclk_out    = ((mode_ff == psl_pkg::MODE_SHIFT) || (mode_ff == psl_pkg::MODE_EXTRA))
                           && !phase_ff;
      result.data0_out   = (mode_ff == psl_pkg::MODE_SHIFT) && shift_ff[0];
      result.need_byte   = (mode_ff == psl_pkg::MODE_FETCH);
      result.byte_index  = sent_in;
      case (mode_ff)
         psl_pkg::MODE_IDLE: result.run_status = psl_pkg::STATUS_IDLE;
         psl_pkg::MODE_DONE: result.run_status = psl_pkg::STATUS_DONE;
         psl_pkg::MODE_FAIL: result.run_status = psl_pkg::STATUS_FAIL;
         default:            result.run_status = psl_pkg::STATUS_BUSY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= psl_pkg::MODE_IDLE;
         shift_ff   <= '0;
         bit_cnt_ff <= '0;
         phase_ff   <= 1'b0;
         sent_ff    <= '0;
         extra_ff   <= '0;
      end else if (step_en) begin
         mode_ff    <= mode_in;
         shift_ff   <= shift_in;
         bit_cnt_ff <= bit_cnt_in;
         phase_ff   <= phase_in;
         sent_ff    <= sent_in;
         extra_ff   <= extra_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/psl_out_reg.sv
// result register: holds one result beat while the receiver stalls
`default_nettype none
module psl_out_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire psl_pkg::result_type result,
   input  wire logic                rsp_stall,
   output      logic                rsp_valid,
   output      logic                ready,
   output      psl_pkg::result_type rsp_data
);

   logic                vld_ff, vld_in;
   psl_pkg::result_type data_ff;

   assign ready  = !vld_ff || !rsp_stall;
   assign vld_in = load ? 1'b1 : (vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else       vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= result;
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;

endmodule
`default_nettype wire

FILE: rtl/core/fpga_passive_serial_loader_unit.sv
// top level of the passive serial configuration master
//
// usage
//  - req channel: one beat per tick with start_req, sampled nstatus and
//    cdone pins, and an optional image byte (byte_valid)
//  - rsp channel: one beat per tick with the nconfig, dclk and data0 pin
//    levels, need_byte, byte_index and run_status
//  - csr channel: index 0 image_bytes, index 1 extra_clocks, always ready;
//    write only while no tick is in flight
//  - pipeline: a req beat, once accepted, passes the input register and then
//    the result register before its rsp beat is valid
//  - throughput: one tick per cycle while rsp_stall is low, set by the single
//    pass of the sequencer between the input register and the result register
//  - reset: run idle, image_bytes all ones, extra_clocks 4000, both
//    pipeline registers empty
//  - rsp stall: the result register holds its beat; the input register
//    keeps its tick and req_stall rises once both stages are full
`default_nettype none
module fpga_passive_serial_loader_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // tick input
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic                                req_start_req,
   input  wire logic                                req_nstatus_pin,
   input  wire logic                                req_cdone_pin,
   input  wire logic                                req_byte_valid,
   input  wire logic [psl_pkg::BYTE_WIDTH-1:0]      req_image_byte,
   // pin levels out
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic                                rsp_nconfig_out,
   output      logic                                rsp_dclk_out,
   output      logic                                rsp_data0_out,
   output      logic                                rsp_need_byte,
   output      logic [psl_pkg::INDEX_WIDTH-1:0]     rsp_byte_index,
   output      logic [psl_pkg::STATUS_WIDTH-1:0]    rsp_run_status,
   // configuration writes
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [psl_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  wire logic [psl_pkg::CSR_DAT_WIDTH-1:0]   csr_wdata
);

   logic                            in_vld_ff, in_vld_in;
   psl_pkg::tick_type               tick_ff;
   logic                            out_ready;
   logic                            advance;
   logic                            take;
   logic [psl_pkg::IMAGE_WIDTH-1:0] image_bytes;
   logic [psl_pkg::EXTRA_WIDTH-1:0] extra_clocks;
   psl_pkg::result_type             result;
   psl_pkg::result_type             rsp_data;

   // tick moves to the result register when that one is free or draining
   assign advance   = in_vld_ff && out_ready;
   // input register takes a beat when empty or emptying this cycle
   assign req_stall = in_vld_ff && !out_ready;
   assign take      = req_valid && !req_stall;
   assign in_vld_in = take ? 1'b1 : (in_vld_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) in_vld_ff <= 1'b0;
      else       in_vld_ff <= in_vld_in;
   end

   // payload of the input register, no reset needed
   always_ff @(posedge clock) begin
      if (take) begin
         tick_ff.start_req   <= req_start_req;
         tick_ff.nstatus_pin <= req_nstatus_pin;
         tick_ff.cdone_pin   <= req_cdone_pin;
         tick_ff.byte_valid  <= req_byte_valid;
         tick_ff.image_byte  <= req_image_byte;
      end
   end

   psl_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .image_bytes  (image_bytes),
      .extra_clocks (extra_clocks)
   );

   // state advances exactly once per tick, when its result is stored
   psl_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .tick         (tick_ff),
      .image_bytes  (image_bytes),
      .extra_clocks (extra_clocks),
      .result       (result)
   );

   psl_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .ready     (out_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_nconfig_out = rsp_data.nconfig_out;
   assign rsp_dclk_out    = rsp_data.dclk_out;
   assign rsp_data0_out   = rsp_data.data0_out;
   assign rsp_need_byte   = rsp_data.need_byte;
   assign rsp_byte_index  = rsp_data.byte_index;
   assign rsp_run_status  = rsp_data.run_status;

endmodule
`default_nettype wire

FILE: rtl/core/psl_checker.sv
// port level checks of the loader, bound to the top level
`default_nettype none
module psl_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic                             rsp_nconfig_out,
   input wire logic                             rsp_dclk_out,
   input wire logic                             rsp_data0_out,
   input wire logic                             rsp_need_byte,
   input wire logic [psl_pkg::INDEX_WIDTH-1:0]  rsp_byte_index,
   input wire logic [psl_pkg::STATUS_WIDTH-1:0] rsp_run_status
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_nconfig_out)
         && $stable(rsp_dclk_out) && $stable(rsp_data0_out)
         && $stable(rsp_byte_index) && $stable(rsp_run_status))
      else $error("rsp beat changed under stall");

   // no clocking while the device is held in reset
   a_dclk_cfg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dclk_out |-> rsp_nconfig_out)
      else $error("dclk high with nconfig low");

   // waiting for a byte means the serial pins are quiet
   a_need_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_need_byte |-> !rsp_dclk_out && !rsp_data0_out
         && (rsp_run_status == psl_pkg::STATUS_BUSY))
      else $error("pins active while waiting for a byte");

   // nconfig low only during a run
   a_hold_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_nconfig_out |-> (rsp_run_status == psl_pkg::STATUS_BUSY))
      else $error("nconfig low outside a run");

   // reset empties the result stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind fpga_passive_serial_loader_unit psl_checker u_psl_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_nconfig_out (rsp_nconfig_out),
   .rsp_dclk_out    (rsp_dclk_out),
   .rsp_data0_out   (rsp_data0_out),
   .rsp_need_byte   (rsp_need_byte),
   .rsp_byte_index  (rsp_byte_index),
   .rsp_run_status  (rsp_run_status)
);
`default_nettype wire

FILE: tb/fpga_passive_serial_loader_unit_tb.sv
// testbench: passive serial loader checked beat by beat against a pin-level predictor
`timescale 1ns / 100ps
module fpga_passive_serial_loader_unit_tb;
   import psl_pkg::*;

   // run length and pacing
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int RANDOM_PHASES   = 12;
   localparam int TICKS_PER_PHASE = 85;
   localparam int PIPE_SETTLE     = 4;    // two register stages plus margin
   localparam int HOLD_OFF_CYCLES = 100;  // long receiver stall, fills both stages
   localparam int NOISE_PCT       = 10;

   // one directed tick: stimulus, plus a typed-in expectation where obvious
   typedef struct {
      tick_type   stim;
      bit         typed;
      result_type want;
   } script_row_type;

   // dut pins, every input known from time zero
   logic                     clock             = 1'b0;
   logic                     reset             = 1'b1;
   logic                     req_valid         = 1'b0;
   logic                     req_stall;
   logic                     req_start_req     = 1'b0;
   logic                     req_nstatus_pin   = 1'b0;
   logic                     req_cdone_pin     = 1'b0;
   logic                     req_byte_valid    = 1'b0;
   logic [BYTE_WIDTH-1:0]    req_image_byte    = '0;
   logic                     rsp_valid;
   logic                     rsp_stall         = 1'b0;
   logic                     rsp_nconfig_out;
   logic                     rsp_dclk_out;
   logic                     rsp_data0_out;
   logic                     rsp_need_byte;
   logic [INDEX_WIDTH-1:0]   rsp_byte_index;
   logic [STATUS_WIDTH-1:0]  rsp_run_status;
   logic                     csr_valid         = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_WIDTH-1:0] csr_index         = CSR_IMAGE_BYTES;
   logic [CSR_DAT_WIDTH-1:0] csr_wdata         = '0;

   // predictor copy of the loader state and its registers
   mode_type               ld_mode          = MODE_IDLE;
   logic [BYTE_WIDTH-1:0]  ld_shift         = '0;
   logic [2:0]             ld_bit           = '0;
   logic                   ld_phase         = 1'b0;
   logic [INDEX_WIDTH-1:0] ld_sent          = '0;
   logic [EXTRA_WIDTH-1:0] ld_extra         = '0;
   logic [IMAGE_WIDTH-1:0] cfg_image_bytes  = IMAGE_RESET;
   logic [EXTRA_WIDTH-1:0] cfg_extra_clocks = EXTRA_RESET;

   // expected pin levels, oldest first
   result_type     pin_expect_q[$];
   script_row_type script_q[$];

   int mismatch_count   = 0;
   int beats_seen       = 0;
   int cycle_count      = 0;
   int req_max_gap      = 0;
   int rsp_max_gap      = 0;
   int done_after_bytes = 1;  // image byte count at which the fake fpga raises cdone

   fpga_passive_serial_loader_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_start_req     (req_start_req),
      .req_nstatus_pin   (req_nstatus_pin),
      .req_cdone_pin     (req_cdone_pin),
      .req_byte_valid    (req_byte_valid),
      .req_image_byte    (req_image_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_nconfig_out   (rsp_nconfig_out),
      .rsp_dclk_out      (rsp_dclk_out),
      .rsp_data0_out     (rsp_data0_out),
      .rsp_need_byte     (rsp_need_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_run_status    (rsp_run_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #1 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t ns: cycle limit reached, %0d beats still expected", $time,
                  pin_expect_q.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // run is not in progress: a start would be taken
   function automatic bit run_at_rest();
      return ld_mode inside {MODE_IDLE, MODE_DONE, MODE_FAIL};
   endfunction

   // advance the loader by one tick, return the pin levels of that tick
   function automatic result_type advance_loader(input tick_type t);
      result_type r;
      r = '0;
      r.nconfig_out = 1'b1;
      case (ld_mode)
         MODE_IDLE: r.run_status = STATUS_IDLE;
         MODE_DONE: r.run_status = STATUS_DONE;
         MODE_FAIL: r.run_status = STATUS_FAIL;
         default:   r.run_status = STATUS_BUSY;
      endcase
      case (ld_mode)
         MODE_HOLD: begin
            // nconfig low until the fpga pulls nstatus or cdone low
            r.nconfig_out = 1'b0;
            if (!t.nstatus_pin || !t.cdone_pin) ld_mode = MODE_WAITST;
         end
         MODE_WAITST: begin
            if (t.nstatus_pin) ld_mode = MODE_FETCH;
         end
         MODE_FETCH: begin
            r.need_byte = 1'b1;
            if (t.byte_valid) begin
               ld_shift = t.image_byte;
               ld_bit   = '0;
               ld_phase = 1'b0;
               // counter saturates at the image length and at its own width
               if (ld_sent < cfg_image_bytes && ld_sent != '1) ld_sent = ld_sent + 1'b1;
               ld_mode = MODE_SHIFT;
            end
         end
         MODE_SHIFT: begin
            r.data0_out = ld_shift[0];
            if (!ld_phase) begin
               r.dclk_out = 1'b1;
               ld_phase   = 1'b1;
            end else begin
               ld_phase = 1'b0;
               ld_shift = ld_shift >> 1;
               if (ld_bit == 3'(BITS_PER_BYTE - 1)) begin
                  ld_bit = '0;
                  if (t.cdone_pin || ld_sent >= cfg_image_bytes) begin
                     // stopping at the image end is a failure even with cdone high
                     if (ld_sent < cfg_image_bytes) begin
                        ld_extra = cfg_extra_clocks;
                        ld_mode  = (ld_extra == '0) ? MODE_DONE : MODE_EXTRA;
                     end else begin
                        ld_mode = MODE_FAIL;
                     end
                  end else begin
                     ld_mode = MODE_FETCH;
                  end
               end else begin
                  ld_bit = ld_bit + 1'b1;
               end
            end
         end
         MODE_EXTRA: begin
            if (!ld_phase) begin
               r.dclk_out = 1'b1;
               ld_phase   = 1'b1;
            end else begin
               ld_phase = 1'b0;
               ld_extra = ld_extra - 1'b1;
               if (ld_extra == '0) ld_mode = MODE_DONE;
            end
         end
         default: begin
            // idle, done or failed: a start clears the run
            if (t.start_req) begin
               ld_sent  = '0;
               ld_bit   = '0;
               ld_phase = 1'b0;
               ld_shift = '0;
               ld_extra = '0;
               ld_mode  = MODE_HOLD;
            end
         end
      endcase
      r.byte_index = ld_sent;
      return r;
   endfunction

   // plausible fpga pin behavior for the state the next tick will meet,
   // with an occasional fully random tick thrown in
   function automatic tick_type make_tick(input int noise_pct, input bit allow_start);
      tick_type t;
      t = '0;
      if (int'($urandom_range(0, 99)) < noise_pct) return tick_type'(12'($urandom));
      t.image_byte = BYTE_WIDTH'($urandom);
      case (ld_mode)
         MODE_HOLD: begin
            t.nstatus_pin = ($urandom_range(0, 2) != 0);
            t.cdone_pin   = ($urandom_range(0, 5) != 0);
         end
         MODE_WAITST: t.nstatus_pin = 1'($urandom_range(0, 1));
         MODE_FETCH: begin
            t.nstatus_pin = 1'b1;
            t.byte_valid  = ($urandom_range(0, 3) != 0);
         end
         MODE_SHIFT: begin
            t.nstatus_pin = 1'b1;
            t.cdone_pin   = (ld_sent >= done_after_bytes);
            t.byte_valid  = 1'($urandom_range(0, 1));
         end
         MODE_EXTRA, MODE_DONE: begin
            t.nstatus_pin = 1'b1;
            t.cdone_pin   = 1'b1;
         end
         default: t.nstatus_pin = 1'b1;
      endcase
      if (run_at_rest()) begin
         if (allow_start && $urandom_range(0, 2) == 0) begin
            t.start_req      = 1'b1;
            done_after_bytes = $urandom_range(1, 5);
         end
      end else begin
         // starts while busy are ignored by the block
         t.start_req = ($urandom_range(0, 15) == 0);
      end
      return t;
   endfunction

   // write both registers back to back, valid stays high between the beats
   task automatic set_loader_config(input logic [IMAGE_WIDTH-1:0] image_len,
                                    input logic [EXTRA_WIDTH-1:0] pulses);
      csr_valid <= 1'b1;
      csr_index <= CSR_IMAGE_BYTES;
      csr_wdata <= CSR_DAT_WIDTH'(image_len);
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_EXTRA_CLOCKS;
      csr_wdata <= CSR_DAT_WIDTH'(pulses);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cfg_image_bytes  = image_len;
      cfg_extra_clocks = pulses;
   endtask

   // offer one tick after a random gap, predict it once accepted
   task automatic offer_tick(input tick_type stim, input bit typed, input result_type want);
      int         gap;
      result_type predicted;
      gap = $urandom_range(0, req_max_gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_start_req   <= stim.start_req;
      req_nstatus_pin <= stim.nstatus_pin;
      req_cdone_pin   <= stim.cdone_pin;
      req_byte_valid  <= stim.byte_valid;
      req_image_byte  <= stim.image_byte;
      do @(posedge clock); while (req_stall);
      predicted = advance_loader(stim);
      pin_expect_q.push_back(typed ? want : predicted);
   endtask

   // stop offering, wait out every expected beat and the pipeline
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pin_expect_q.size() != 0) @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   task automatic compare_field(input string pin, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0h got %0h", $time, pin, want, got);
         mismatch_count++;
      end
   endtask

   // result side: random stall per beat, a long hold-off now and then
   initial begin : result_side
      result_type want;
      int         stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pin_expect_q.size() == 0) begin
               $display("%0t ns: result beat with nothing expected", $time);
               mismatch_count++;
            end else begin
               want = pin_expect_q.pop_front();
               compare_field("nconfig_out", want.nconfig_out, rsp_nconfig_out);
               compare_field("dclk_out", want.dclk_out, rsp_dclk_out);
               compare_field("data0_out", want.data0_out, rsp_data0_out);
               compare_field("need_byte", want.need_byte, rsp_need_byte);
               compare_field("byte_index", want.byte_index, rsp_byte_index);
               compare_field("run_status", want.run_status, rsp_run_status);
            end
            beats_seen++;
            stall_left = $urandom_range(0, rsp_max_gap);
            // hold off long enough for the input side to back up
            if (beats_seen % 600 == 300) stall_left = HOLD_OFF_CYCLES;
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   // stimulus: directed script, random phases, then one long extra-clock run
   initial begin : stimulus
      bit long_started;

      // control nibble is start, nstatus, cdone, byte_valid
      // expected nibble is nconfig, dclk, data0, need_byte
      script_q.push_back('{{4'b0110, 8'h00}, 1'b1, {4'b1000, 24'd0, STATUS_IDLE}});
      // start from idle
      script_q.push_back('{{4'b1110, 8'h00}, 1'b1, {4'b1000, 24'd0, STATUS_IDLE}});
      // nconfig held low while the fpga keeps both pins high
      script_q.push_back('{{4'b0110, 8'h00}, 1'b1, {4'b0000, 24'd0, STATUS_BUSY}});
      // start while busy is ignored, nstatus low ends the hold
      script_q.push_back('{{4'b1010, 8'h00}, 1'b1, {4'b0000, 24'd0, STATUS_BUSY}});
      script_q.push_back('{{4'b0000, 8'h00}, 1'b1, {4'b1000, 24'd0, STATUS_BUSY}});
      script_q.push_back('{{4'b0100, 8'h00}, 1'b1, {4'b1000, 24'd0, STATUS_BUSY}});
      // no byte offered, block keeps asking
      script_q.push_back('{{4'b0100, 8'hA5}, 1'b1, {4'b1001, 24'd0, STATUS_BUSY}});
      script_q.push_back('{{4'b0101, 8'hFF}, 1'b1, {4'b1001, 24'd1, STATUS_BUSY}});
      // shift out the only byte, cdone rises on its last tick
      for (int k = 0; k < 2 * BITS_PER_BYTE; k++)
         script_q.push_back('{{1'b0, 1'b1, k == 2 * BITS_PER_BYTE - 1, 1'b0, 8'h00},
                              1'b0, '0});
      // image end reached with cdone high still counts as failure
      script_q.push_back('{{4'b0110, 8'h00}, 1'b1, {4'b1000, 24'd1, STATUS_FAIL}});
      // restart from failed clears the byte counter
      script_q.push_back('{{4'b1111, 8'hFF}, 1'b1, {4'b1000, 24'd0, STATUS_FAIL}});

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // single-byte image so the directed run fails at its end
      set_loader_config(24'd1, 16'd1);
      req_max_gap = 12;
      rsp_max_gap = 12;
      foreach (script_q[i]) offer_tick(script_q[i].stim, script_q[i].typed, script_q[i].want);
      drain_results();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         // first phases pin down the register extremes
         case (phase)
            0:       set_loader_config(24'd0, 16'd0);
            1:       set_loader_config(24'd1, 16'd0);
            2:       set_loader_config('1, 16'd1);
            3:       set_loader_config(24'd3, 16'd2);
            default: set_loader_config(($urandom_range(0, 3) == 0) ? '1 :
                                       IMAGE_WIDTH'($urandom_range(0, 8)),
                                       EXTRA_WIDTH'($urandom_range(0, 12)));
         endcase
         // some phases run with no idling on one or both sides
         req_max_gap = (phase == 0 || $urandom_range(0, 2) == 0) ? 0 : 12;
         rsp_max_gap = (phase == 0 || $urandom_range(0, 2) == 0) ? 0 : 12;
         repeat (TICKS_PER_PHASE) offer_tick(make_tick(NOISE_PCT, 1'b1), 1'b0, '0);
         drain_results();
      end

      // let any open run finish before a longer extra-clock run
      while (!run_at_rest()) offer_tick(make_tick(0, 1'b0), 1'b0, '0);
      drain_results();
      set_loader_config('1, 16'd40);
      req_max_gap  = 0;
      rsp_max_gap  = 0;
      long_started = 1'b0;
      while (!(long_started && run_at_rest())) begin
         offer_tick(make_tick(0, !long_started), 1'b0, '0);
         if (ld_mode == MODE_HOLD) long_started = 1'b1;
      end
      drain_results();

      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/psl_pkg.sv
rtl/core/psl_csr.sv
rtl/core/psl_engine.sv
rtl/core/psl_out_reg.sv
rtl/core/fpga_passive_serial_loader_unit.sv
rtl/core/psl_checker.sv
tb/fpga_passive_serial_loader_unit_tb.sv
